// ===== hdl/mhlr_pkg.sv =====
// shared constants and codes for the min-heap load and remove block
`default_nettype none

package mhlr_pkg;

  // heap sizing
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child positions reach 2 * (CAPACITY - 1) + 2
  localparam int PTR_W    = ADDR_W + 2;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 6;
  localparam int CNT_OUT_W = 7;
  localparam int STAT_W    = 2;

  // width used to compare the request index against the count
  localparam int CMP_W = (IDX_W > PTR_W) ? IDX_W : PTR_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/mhlr_ram.sv =====
// heap storage: one write port, two registered read ports
`default_nettype none

module mhlr_ram #(
  parameter int Depth = 64,
  parameter int DataW = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  output logic      [DataW-1:0] rdata_a_o,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, registered
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== hdl/min_heap_load_and_remove.sv =====
// top level: array-stored binary min-heap with load, remove-minimum and read requests
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) as req_type_i,
// value_i and index_i. A load appends value_i at the end of the array, a remove
// returns the root and sifts the last entry down from the root, a read returns
// the entry at index_i. Every request gives exactly one result on the output
// channel (out_valid_o / out_stall_i): result_value_o, count_after_o, status_o.
// One request is worked on at a time; the finished result sits in an output
// register, so the next request is taken while the previous result waits.
// A load writes the new entry at once, a read waits for the memory read, and a
// remove reads the root and last entry, then the sift-down compares the children
// of at most 5 heap levels (64 entries, at most 63 remain after the remove), with
// a place step for the moved entry when it sinks to a leaf. Each level reads both
// children at once from the dual-read storage memory.
// Reset empties the heap (count zero) and clears the output channel; the
// storage itself is not cleared, entries beyond the count are never visible.
// While the receiver stalls, the result holds steady and a finished request
// waits in its final state, stalling the input channel.
`default_nettype none

module min_heap_load_and_remove (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic        [mhlr_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic signed [mhlr_pkg::DATA_W-1:0]    value_i,
  input  wire logic        [mhlr_pkg::IDX_W-1:0]     index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed      [mhlr_pkg::DATA_W-1:0]    result_value_o,
  output logic             [mhlr_pkg::CNT_OUT_W-1:0] count_after_o,
  output logic             [mhlr_pkg::STAT_W-1:0]    status_o
);

  import mhlr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RM_WAIT,
    ST_SIFT,
    ST_PLACE,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [ADDR_W-1:0]         pos_q, pos_d;
  logic signed [DATA_W-1:0]  cur_q, cur_d;
  logic signed [DATA_W-1:0]  pval_q, pval_d;
  logic [STAT_W-1:0]         pstat_q, pstat_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0]  out_value_q;
  logic [CNT_OUT_W-1:0]      out_count_q;
  logic [STAT_W-1:0]         out_status_q;
  logic                      out_load;

  // memory ports
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b;
  logic signed [DATA_W-1:0]  rd_data_a, rd_data_b;

  // sift-down helpers
  logic [PTR_W-1:0]          cnt_ext;
  logic [PTR_W-1:0]          lft, rgt;
  logic                      pick_right;
  logic signed [DATA_W-1:0]  pick_val;
  logic [PTR_W-1:0]          pick_idx;
  logic [ADDR_W-1:0]         pick_addr;
  logic [PTR_W-1:0]          next_lft, next_rgt;
  logic [CNT_W-1:0]          count_dec;
  logic                      in_xfer;
  logic                      idx_bad;

  mhlr_ram #(
    .Depth (CAPACITY),
    .DataW (DATA_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (rd_addr_a),
    .rdata_a_o (rd_data_a),
    .raddr_b_i (rd_addr_b),
    .rdata_b_o (rd_data_b)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign count_dec  = count_q - 1'b1;
  assign idx_bad    = (CMP_W'(index_i) >= CMP_W'(count_q)) ||
                      (CMP_W'(index_i) >= CMP_W'(CAPACITY));

  // children of the current position and the smaller of the two
  assign cnt_ext    = PTR_W'(count_q);
  assign lft        = PTR_W'({pos_q, 1'b1});
  assign rgt        = lft + 1'b1;
  assign pick_right = (rgt < cnt_ext) && (rd_data_b < rd_data_a);
  assign pick_val   = pick_right ? rd_data_b : rd_data_a;
  assign pick_idx   = pick_right ? rgt : lft;
  assign pick_addr  = pick_idx[ADDR_W-1:0];
  assign next_lft   = PTR_W'({pick_addr, 1'b1});
  assign next_rgt   = next_lft + 1'b1;

  // output register is free or being freed this cycle
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // request sequencing and memory access
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    pval_d      = pval_q;
    pstat_d     = pstat_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = cur_q;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pval_d  = '0;
          pstat_d = STAT_OK;
          state_d = ST_DONE;
          unique case (req_type_i)
            REQ_LOAD: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                pstat_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[ADDR_W-1:0];
                mem_wdata = value_i;
                count_d   = count_q + 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (count_q == '0) begin
                pstat_d = STAT_EMPTY;
              end else begin
                rd_addr_a = '0;
                rd_addr_b = count_dec[ADDR_W-1:0];
                count_d   = count_dec;
                state_d   = ST_RM_WAIT;
              end
            end
            REQ_READ: begin
              if (idx_bad) begin
                pstat_d = STAT_RANGE;
              end else begin
                rd_addr_a = ADDR_W'(index_i);
                state_d   = ST_RD_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // root and last entry arrive; last entry starts at the root
      ST_RM_WAIT: begin
        pval_d = rd_data_a;
        cur_d  = rd_data_b;
        pos_d  = '0;
        if (PTR_W'(1) < cnt_ext) begin
          rd_addr_a = ADDR_W'(1);
          rd_addr_b = ADDR_W'(2);
          state_d   = ST_SIFT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = rd_data_b;
          state_d   = ST_DONE;
        end
      end

      // one level per cycle: move the smaller child up, fetch the next pair
      ST_SIFT: begin
        mem_we = 1'b1;
        if (pick_val < cur_q) begin
          mem_wdata = pick_val;
          pos_d     = pick_addr;
          if (next_lft < cnt_ext) begin
            rd_addr_a = next_lft[ADDR_W-1:0];
            rd_addr_b = next_rgt[ADDR_W-1:0];
          end else begin
            state_d = ST_PLACE;
          end
        end else begin
          state_d = ST_DONE;
        end
      end

      // moved entry lands on a leaf
      ST_PLACE: begin
        mem_we  = 1'b1;
        state_d = ST_DONE;
      end

      ST_RD_WAIT: begin
        pval_d  = rd_data_a;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cur_q   <= cur_d;
    pval_q  <= pval_d;
    pstat_q <= pstat_d;
    if (out_load) begin
      out_value_q  <= pval_q;
      out_count_q  <= CNT_OUT_W'(count_q);
      out_status_q <= pstat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign count_after_o  = out_count_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire
